FILE: hdl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Widths, payload types and defaults shared by the day distance block.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int unsigned DAY_W      = 5;
    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned DIST_W     = 22;
    // day number from 1/1/1 for any 14-bit year stays below 2**23
    localparam int unsigned DAYNUM_W   = 23;
    localparam int unsigned MAX_YEAR_DEFAULT = 9999;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic                ok;
        logic [DAYNUM_W-1:0] daynum;
    } date_info_t;

endpackage

FILE: hdl/gdd_date_pair_if.sv
// ----------------------------------------------------------------------------
// gdd_date_pair_if
// Input channel: one word carries two calendar dates.
// ----------------------------------------------------------------------------
interface gdd_date_pair_if;

    logic                         valid;
    logic                         ready;
    logic [gdd_pkg::DAY_W-1:0]    first_day;
    logic [gdd_pkg::MONTH_W-1:0]  first_month;
    logic [gdd_pkg::YEAR_W-1:0]   first_year;
    logic [gdd_pkg::DAY_W-1:0]    second_day;
    logic [gdd_pkg::MONTH_W-1:0]  second_month;
    logic [gdd_pkg::YEAR_W-1:0]   second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );

    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );

endinterface

FILE: hdl/gdd_result_if.sv
// ----------------------------------------------------------------------------
// gdd_result_if
// Output channel: day distance and per-date validity flags.
// ----------------------------------------------------------------------------
interface gdd_result_if;

    logic                        valid;
    logic                        ready;
    logic [gdd_pkg::DIST_W-1:0]  day_distance;
    logic                        first_ok;
    logic                        second_ok;

    modport source (
        output valid, day_distance, first_ok, second_ok,
        input  ready
    );

    modport sink (
        input  valid, day_distance, first_ok, second_ok,
        output ready
    );

endinterface

FILE: hdl/gdd_date_unit.sv
// ----------------------------------------------------------------------------
// gdd_date_unit
// Checks one date and converts it to a day number counted from 1/1/1 = 1.
// ----------------------------------------------------------------------------
module gdd_date_unit #(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEFAULT
) (
    input  gdd_pkg::date_t      date,
    output gdd_pkg::date_info_t info
);

    localparam int unsigned YCMP_W = 17;
    localparam logic [YCMP_W-1:0] YEAR_LIMIT = YCMP_W'(MAX_YEAR);
    localparam int unsigned Q4_W = gdd_pkg::YEAR_W - 2;

    // floor(q / 25) = (q * 5243) >> 17, exact for 12-bit q
    localparam logic [12:0] RECIP_25  = 13'd5243;
    localparam int unsigned RECIP_SH  = 17;
    // q divisible by 25 <=> (q * inv25 mod 2**12) <= 4095 / 25
    localparam logic [Q4_W-1:0] INV_25    = 12'd3113;
    localparam logic [Q4_W-1:0] DIV25_MAX = 12'd163;

    localparam logic [gdd_pkg::DAYNUM_W-1:0] DAYS_PER_YEAR = 23'd365;

    function automatic logic [8:0] month_start(input logic [gdd_pkg::MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [gdd_pkg::DAY_W-1:0] month_len(
        input logic [gdd_pkg::MONTH_W-1:0] m,
        input logic                        leap
    );
        logic [gdd_pkg::DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    logic [gdd_pkg::YEAR_W-1:0]   prev_year;
    logic [Q4_W-1:0]              prev_q4;
    logic [Q4_W+12:0]             prev_c100_prod;
    logic [7:0]                   prev_c100;
    logic [5:0]                   prev_c400;
    logic [gdd_pkg::DAYNUM_W-1:0] year_days;
    logic [2*Q4_W-1:0]            div25_prod;
    logic                         by4;
    logic                         by100;
    logic                         by400;
    logic                         leap;
    logic                         year_ok;
    logic                         month_ok;
    logic                         day_ok;

    always_comb
    begin
        prev_year      = date.year - 14'd1;
        prev_q4        = prev_year[gdd_pkg::YEAR_W-1:2];
        prev_c100_prod = prev_q4 * RECIP_25;
        prev_c100      = prev_c100_prod[RECIP_SH+7:RECIP_SH];
        prev_c400      = prev_c100[7:2];
        year_days      = gdd_pkg::DAYNUM_W'(prev_year) * DAYS_PER_YEAR;

        div25_prod = date.year[gdd_pkg::YEAR_W-1:2] * INV_25;
        by4        = (date.year[1:0] == 2'b00);
        by100      = by4 && (div25_prod[Q4_W-1:0] <= DIV25_MAX);
        by400      = by100 && (date.year[3:2] == 2'b00);
        leap       = (by4 && !by100) || by400;

        year_ok  = (date.year != '0) && ({3'b000, date.year} <= YEAR_LIMIT);
        month_ok = (date.month >= 4'd1) && (date.month <= 4'd12);
        day_ok   = (date.day != '0) && (date.day <= month_len(date.month, leap));

        info.ok     = year_ok && month_ok && day_ok;
        info.daynum = year_days
                    + gdd_pkg::DAYNUM_W'(prev_q4)
                    - gdd_pkg::DAYNUM_W'(prev_c100)
                    + gdd_pkg::DAYNUM_W'(prev_c400)
                    + gdd_pkg::DAYNUM_W'(month_start(date.month))
                    + gdd_pkg::DAYNUM_W'(leap && (date.month > 4'd2))
                    + gdd_pkg::DAYNUM_W'(date.day);
    end

endmodule

FILE: hdl/gregorian_day_difference.sv
// ----------------------------------------------------------------------------
// gregorian_day_difference
// Validates two Gregorian dates and returns the absolute day distance.
// ----------------------------------------------------------------------------
// channel   dir  modport  payload
// dates     in   sink     first_/second_ day, month, year
// distance  out  source   day_distance, first_ok, second_ok
//
// Three register stages: input word, day numbers, result. An accepted word
// moves through them in order; one word per cycle sustained if not stalled.
// Each stage advances when the stage after it is empty or advancing, so a
// stall on distance backs up through the stages and dates.ready drops only
// when all three hold a word. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module gregorian_day_difference #(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    gdd_date_pair_if.sink   dates,
    gdd_result_if.source    distance
);

    logic                s0_valid_reg;
    gdd_pkg::date_t      s0_first_reg;
    gdd_pkg::date_t      s0_second_reg;
    logic                s1_valid_reg;
    gdd_pkg::date_info_t s1_first_reg;
    gdd_pkg::date_info_t s1_second_reg;
    logic                out_valid_reg;
    logic [gdd_pkg::DIST_W-1:0] dist_reg;
    logic                first_ok_reg;
    logic                second_ok_reg;

    gdd_pkg::date_info_t first_info;
    gdd_pkg::date_info_t second_info;
    logic [gdd_pkg::DAYNUM_W-1:0] dist_next;

    logic adv_out;
    logic adv_s1;
    logic adv_s0;

    assign adv_out = !out_valid_reg || distance.ready;
    assign adv_s1  = !s1_valid_reg || adv_out;
    assign adv_s0  = !s0_valid_reg || adv_s1;

    assign dates.ready           = adv_s0;
    assign distance.valid        = out_valid_reg;
    assign distance.day_distance = dist_reg;
    assign distance.first_ok     = first_ok_reg;
    assign distance.second_ok    = second_ok_reg;

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_first (
        .date (s0_first_reg),
        .info (first_info)
    );

    gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_second (
        .date (s0_second_reg),
        .info (second_info)
    );

    always_comb
    begin
        if (!(s1_first_reg.ok && s1_second_reg.ok))
            dist_next = '0;
        else if (s1_first_reg.daynum >= s1_second_reg.daynum)
            dist_next = s1_first_reg.daynum - s1_second_reg.daynum;
        else
            dist_next = s1_second_reg.daynum - s1_first_reg.daynum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s0)
                s0_valid_reg <= dates.valid;
            if (adv_s1)
                s1_valid_reg <= s0_valid_reg;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s0)
        begin
            s0_first_reg  <= '{day: dates.first_day, month: dates.first_month,
                               year: dates.first_year};
            s0_second_reg <= '{day: dates.second_day, month: dates.second_month,
                               year: dates.second_year};
        end
        if (adv_s1)
        begin
            s1_first_reg  <= first_info;
            s1_second_reg <= second_info;
        end
        if (adv_out)
        begin
            dist_reg      <= dist_next[gdd_pkg::DIST_W-1:0];
            first_ok_reg  <= s1_first_reg.ok;
            second_ok_reg <= s1_second_reg.ok;
        end
    end

    a_dist_needs_both_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (dist_reg != '0)) |-> (first_ok_reg && second_ok_reg)
    ) else $error("nonzero distance with an invalid date");

    a_s1_moves_to_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv_out) |=> out_valid_reg
    ) else $error("day number stage word lost");

    a_ready_low_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !dates.ready |-> (s0_valid_reg && s1_valid_reg && out_valid_reg
                          && !distance.ready)
    ) else $error("input stalled with a free stage");

endmodule

FILE: bench/tb_gregorian_day_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference
// Self-checking bench for the Gregorian day distance block. A queue of date
// pairs, directed corner cases first and random pairs after, feeds a driver
// that offers words at random. A monitor predicts each result when its word
// is taken and checks the distance and both validity flags in order. The
// receiver stalls at random and once holds off long enough to back up the
// pipeline.
// ----------------------------------------------------------------------------
module tb_gregorian_day_difference;

    localparam int unsigned MAX_YEAR   = gdd_pkg::MAX_YEAR_DEFAULT;
    localparam int unsigned N_RANDOM   = 1400;
    localparam int unsigned IDLE_PCT   = 38;
    localparam int unsigned HOLD_CYC   = 150;
    localparam int unsigned HOLD_AFTER = 800;
    localparam int unsigned CALM_LO    = 400;
    localparam int unsigned CALM_HI    = 650;
    localparam int unsigned DRAIN_CYC  = 12;

    typedef struct packed {
        gdd_pkg::date_t first;
        gdd_pkg::date_t second;
    } date_pair_t;

    typedef struct packed {
        logic [gdd_pkg::DIST_W-1:0] distance;
        logic                       first_ok;
        logic                       second_ok;
    } distance_word_t;

    logic clk;
    logic rst_n;

    gdd_date_pair_if date_bus ();
    gdd_result_if    dist_bus ();

    gregorian_day_difference #(
        .MAX_YEAR (MAX_YEAR)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .dates    (date_bus),
        .distance (dist_bus)
    );

    date_pair_t     pending_dates[$];
    distance_word_t expected_distances[$];
    int unsigned    n_offered = 0;
    int unsigned    n_taken   = 0;
    int unsigned    n_errors  = 0;
    int unsigned    hold_left = 0;
    bit             held_once = 1'b0;
    logic           calm;

    assign calm = (n_taken >= CALM_LO) && (n_taken < CALM_HI);

    // ---- calendar predictor ----

    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(gdd_pkg::date_t dt);
        if (dt.year < 1 || dt.year > MAX_YEAR)
            return 1'b0;
        if (dt.month < 1 || dt.month > 12)
            return 1'b0;
        return (dt.day >= 1) && (dt.day <= month_days(dt.month, dt.year));
    endfunction

    function automatic longint unsigned day_count(gdd_pkg::date_t dt);
        longint unsigned p;
        longint unsigned n;
        p = longint'(dt.year) - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int unsigned m = 1; m < dt.month; m++)
            n += month_days(m, dt.year);
        return n + dt.day;
    endfunction

    function automatic distance_word_t predict_distance(date_pair_t pr);
        distance_word_t  w;
        longint unsigned a;
        longint unsigned b;
        w.first_ok  = date_valid(pr.first);
        w.second_ok = date_valid(pr.second);
        w.distance  = '0;
        if (w.first_ok && w.second_ok)
        begin
            a = day_count(pr.first);
            b = day_count(pr.second);
            w.distance = gdd_pkg::DIST_W'((a >= b) ? a - b : b - a);
        end
        return w;
    endfunction

    // ---- stimulus ----

    function automatic gdd_pkg::date_t mk_date(int unsigned d, int unsigned m,
                                               int unsigned y);
        gdd_pkg::date_t dt;
        dt.day   = gdd_pkg::DAY_W'(d);
        dt.month = gdd_pkg::MONTH_W'(m);
        dt.year  = gdd_pkg::YEAR_W'(y);
        return dt;
    endfunction

    task automatic queue_pair(gdd_pkg::date_t a, gdd_pkg::date_t b);
        date_pair_t pr;
        pr.first  = a;
        pr.second = b;
        pending_dates.push_back(pr);
    endtask

    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(1, 5);
        if (r < 16)
            return $urandom_range(MAX_YEAR - 4, MAX_YEAR);
        if (r < 30)
            return 100 * $urandom_range(1, MAX_YEAR / 100);
        return $urandom_range(1, MAX_YEAR);
    endfunction

    function automatic gdd_pkg::date_t good_date();
        int unsigned y;
        int unsigned m;
        int unsigned len;
        y   = pick_year();
        m   = $urandom_range(1, 12);
        len = month_days(m, y);
        if ($urandom_range(0, 3) == 0)
            return mk_date($urandom_range(len - 1, len), m, y);
        return mk_date($urandom_range(1, len), m, y);
    endfunction

    function automatic gdd_pkg::date_t bad_date();
        gdd_pkg::date_t dt;
        dt = good_date();
        case ($urandom_range(0, 4))
            0: dt.day   = gdd_pkg::DAY_W'(month_days(dt.month, dt.year) + 1);
            1: dt.day   = '0;
            2: dt.month = gdd_pkg::MONTH_W'($urandom_range(0, 1) ? 0
                                                              : $urandom_range(13, 15));
            3: dt.year  = '0;
            default: dt.year = gdd_pkg::YEAR_W'($urandom_range(MAX_YEAR + 1,
                                                               2**gdd_pkg::YEAR_W - 1));
        endcase
        return dt;
    endfunction

    function automatic gdd_pkg::date_t raw_date();
        return mk_date($urandom_range(0, 2**gdd_pkg::DAY_W - 1),
                       $urandom_range(0, 2**gdd_pkg::MONTH_W - 1),
                       $urandom_range(0, 2**gdd_pkg::YEAR_W - 1));
    endfunction

    task automatic fill_directed();
        queue_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
        queue_pair(mk_date(31, 15, 16383), mk_date(31, 15, 16383));
        queue_pair(mk_date(1, 1, 1), mk_date(31, 12, MAX_YEAR));
        queue_pair(mk_date(31, 12, MAX_YEAR), mk_date(1, 1, 1));
        queue_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));
        queue_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
        queue_pair(mk_date(29, 2, 1900), mk_date(1, 3, 1900));
        queue_pair(mk_date(29, 2, 2004), mk_date(28, 2, 2001));
        queue_pair(mk_date(29, 2, 2001), mk_date(1, 1, 2001));
        queue_pair(mk_date(30, 2, 2000), mk_date(1, 1, 2000));
        queue_pair(mk_date(31, 4, 2021), mk_date(30, 4, 2021));
        queue_pair(mk_date(30, 6, 1999), mk_date(31, 6, 1999));
        queue_pair(mk_date(15, 13, 2020), mk_date(15, 12, 2020));
        queue_pair(mk_date(1, 1, 10000), mk_date(1, 1, MAX_YEAR));
        queue_pair(mk_date(0, 5, 1500), mk_date(1, 5, 1500));
        queue_pair(mk_date(1, 1, 0), mk_date(31, 12, 1));
        queue_pair(mk_date(31, 12, 1999), mk_date(1, 1, 2000));
        queue_pair(mk_date(1, 3, 1600), mk_date(28, 2, 1600));
        queue_pair(mk_date(31, 1, 8192), mk_date(30, 11, 4095));
        queue_pair(mk_date(16, 8, 5461), mk_date(21, 7, 2730));
        queue_pair(mk_date(31, 12, 400), mk_date(1, 1, 401));
        queue_pair(mk_date(1, 0, 2000), mk_date(1, 14, 2000));
    endtask

    task automatic fill_random();
        int unsigned r;
        for (int unsigned i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                queue_pair(good_date(), good_date());
            else if (r < 80)
                queue_pair(bad_date(), good_date());
            else if (r < 88)
                queue_pair(good_date(), bad_date());
            else
                queue_pair(raw_date(), raw_date());
        end
    endtask

    // ---- clock, reset, run control ----

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int unsigned n_total;
        rst_n = 1'b0;
        fill_directed();
        fill_random();
        n_total = pending_dates.size();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (n_taken < n_total || expected_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---- driver ----

    always @(negedge clk)
    begin : drive_dates
        date_pair_t word;
        if (!rst_n)
        begin
            date_bus.valid <= 1'b0;
        end
        else if (!date_bus.valid || n_taken == n_offered)
        begin
            if (pending_dates.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                word = pending_dates.pop_front();
                date_bus.first_day    <= word.first.day;
                date_bus.first_month  <= word.first.month;
                date_bus.first_year   <= word.first.year;
                date_bus.second_day   <= word.second.day;
                date_bus.second_month <= word.second.month;
                date_bus.second_year  <= word.second.year;
                date_bus.valid        <= 1'b1;
                n_offered             <= n_offered + 1;
            end
            else
            begin
                date_bus.valid <= 1'b0;
            end
        end
    end

    // ---- receiver, with one long hold-off ----

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            dist_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            dist_bus.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end
        else if (!held_once && n_taken >= HOLD_AFTER)
        begin
            held_once      <= 1'b1;
            hold_left      <= HOLD_CYC;
            dist_bus.ready <= 1'b0;
        end
        else
        begin
            dist_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---- monitor ----

    always @(posedge clk)
    begin : watch_words
        date_pair_t     taken;
        distance_word_t want;
        if (rst_n)
        begin
            if (date_bus.valid && date_bus.ready)
            begin
                taken.first  = mk_date(date_bus.first_day, date_bus.first_month,
                                       date_bus.first_year);
                taken.second = mk_date(date_bus.second_day, date_bus.second_month,
                                       date_bus.second_year);
                expected_distances.push_back(predict_distance(taken));
                n_taken <= n_taken + 1;
            end
            if (dist_bus.valid && dist_bus.ready)
            begin
                if (expected_distances.size() == 0)
                begin
                    $error("unexpected result word: day_distance %0d", dist_bus.day_distance);
                    n_errors++;
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (dist_bus.day_distance !== want.distance)
                    begin
                        $error("day_distance: expected %0d, got %0d",
                               want.distance, dist_bus.day_distance);
                        n_errors++;
                    end
                    if (dist_bus.first_ok !== want.first_ok)
                    begin
                        $error("first_ok: expected %0b, got %0b",
                               want.first_ok, dist_bus.first_ok);
                        n_errors++;
                    end
                    if (dist_bus.second_ok !== want.second_ok)
                    begin
                        $error("second_ok: expected %0b, got %0b",
                               want.second_ok, dist_bus.second_ok);
                        n_errors++;
                    end
                end
            end
        end
    end

endmodule

FILE: files.f
hdl/gdd_pkg.sv
hdl/gdd_date_pair_if.sv
hdl/gdd_result_if.sv
hdl/gdd_date_unit.sv
hdl/gregorian_day_difference.sv
bench/tb_gregorian_day_difference.sv
